// ----- rtl/core/npps_pkg.sv -----
// ----------------------------------------------------------------------------
// npps_pkg: shared types and constants for the nearest path point search
// Word formats, command codes, register map and datapath control structs.
// ----------------------------------------------------------------------------
package npps_pkg;

    localparam int MAX_POINTS    = 1024;
    localparam int COORD_WIDTH   = 24;
    localparam int IDX_W         = $clog2(MAX_POINTS);
    localparam int CNT_W         = $clog2(MAX_POINTS + 1);
    localparam int FIELD_W       = 24;
    localparam int INDEX_FIELD_W = 10;
    localparam int DIST_W        = 50;
    localparam int CAP_W         = 24;
    localparam int CAP_SQ_W      = 2 * CAP_W;
    localparam int MAG_W         = 25;
    localparam int STORE_W       = 2 * COORD_WIDTH;

    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(256000);
    localparam logic [DIST_W-1:0] DIST_MAX  = '1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_DISTANCE_CAP = '0;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        logic                      cmd;
        logic                      restart_path;
        logic signed [FIELD_W-1:0] point_x;
        logic signed [FIELD_W-1:0] point_y;
    } t_in_word;

    typedef struct packed {
        logic [INDEX_FIELD_W-1:0]  nearest_index;
        logic signed [FIELD_W-1:0] nearest_x;
        logic signed [FIELD_W-1:0] nearest_y;
        logic [DIST_W-1:0]         best_distance_sq;
        logic                      found;
        logic                      path_empty;
    } t_out_word;

    typedef struct packed {
        logic             load;
        logic             query_start;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             emit;
    } t_dp_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             pipe_busy;
    } t_dp_stat;

    // Low COORD_WIDTH bits of a field pattern.
    function automatic t_coord to_coord(input logic [FIELD_W-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t_coord'(t[COORD_WIDTH-1:0]);
    endfunction

    // Sign-extend or truncate a coordinate to the field width.
    function automatic logic [FIELD_W-1:0] from_coord(input t_coord c);
        logic signed [63:0] t;
        t = 64'(c);
        return t[FIELD_W-1:0];
    endfunction

endpackage

// ----- rtl/core/nearest_path_point_search.sv -----
// ----------------------------------------------------------------------------
// nearest_path_point_search: nearest stored path point to a query point
// Top level: APB register, sequencer, path store and distance datapath.
// ----------------------------------------------------------------------------
// Input words arrive on i_in_valid / o_in_ready. A load word (cmd 0) appends
// one point to the path (restart_path first empties it) and gives no output
// word; a load into a full path of 1024 points is dropped. A query word
// (cmd 1) walks the N stored points, one RAM read per cycle, through a
// three-stage squared distance pipeline, and puts one result word on
// o_out_valid / i_out_ready. The next word is taken once the query's result
// is in the output register; loads go at one per cycle while no query is in
// progress.
// If the receiver stalls, the result holds in the output register; loads
// are still taken, and a following query walks the path and then waits for
// the output register to free up.
// distance_cap is at APB address 0, bits 23:0; the user must write it only
// while idle, which the block does not enforce. Reset empties the path, sets
// the cap to 256000 and leaves the store as is; only written entries are read.
// ----------------------------------------------------------------------------
module nearest_path_point_search (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  npps_pkg::t_in_word                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output npps_pkg::t_out_word                o_out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [npps_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [npps_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [npps_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import npps_pkg::*;

    logic [CAP_W-1:0] r_distance_cap;
    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;
    logic             w_cap_sel;

    assign pready    = 1'b1;
    assign w_cap_sel = (paddr[APB_ADDR_W-1:2] == REG_DISTANCE_CAP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distance_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && w_cap_sel) begin
            r_distance_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = w_cap_sel ? APB_DATA_W'(r_distance_cap) : '0;

    npps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in_data.cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    npps_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_data      (i_in_data),
        .i_cmd          (w_cmd),
        .i_distance_cap (r_distance_cap),
        .o_stat         (w_stat),
        .o_out_data     (o_out_data)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.count <= CNT_W'(MAX_POINTS))
        else $error("point count above path capacity");

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.pipe_busy |-> !o_in_ready)
        else $error("input taken while distance pipeline busy");

    a_restart_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_data.cmd == CMD_LOAD) && i_in_data.restart_path)
        |=> (w_stat.count == CNT_W'(1)))
        else $error("restart load did not leave one point");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_out_valid)
        else $error("result emitted without output valid");
`endif

endmodule

// ----- rtl/core/npps_ram.sv -----
// ----------------------------------------------------------------------------
// npps_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module npps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/npps_ctrl.sv -----
// ----------------------------------------------------------------------------
// npps_ctrl: sequencer for load and query words
// Takes words, walks the path addresses on a query, waits for the distance
// pipeline to drain and hands the result to the output register.
// ----------------------------------------------------------------------------
module npps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  npps_pkg::t_dp_stat i_stat,
    output npps_pkg::t_dp_cmd  o_cmd
);
    import npps_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_addr;
    logic             r_out_valid;

    logic w_in_acc;
    logic w_slot_free;
    logic w_last;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_in_acc    = i_in_valid && (r_state == ST_IDLE);
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_last      = (CNT_W'(r_addr) == (i_stat.count - CNT_W'(1)));

    always_comb begin
        o_cmd.load        = w_in_acc && (i_in_cmd == CMD_LOAD);
        o_cmd.query_start = w_in_acc && (i_in_cmd == CMD_QUERY);
        o_cmd.rd_en       = (r_state == ST_SCAN);
        o_cmd.rd_addr     = r_addr;
        o_cmd.emit        = (r_state == ST_DRAIN) && !i_stat.pipe_busy && w_slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a new word, else hold until the receiver takes it
            r_out_valid <= o_cmd.emit || (r_out_valid && !i_out_ready);
            unique case (r_state)
                ST_IDLE: begin
                    if (o_cmd.query_start) begin
                        r_addr <= '0;
                        // empty path: nothing to walk, go straight to the result
                        r_state <= (i_stat.count == '0) ? ST_DRAIN : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_last) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (o_cmd.emit) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/npps_datapath.sv -----
// ----------------------------------------------------------------------------
// npps_datapath: path store and squared distance pipeline
// Path RAM, point count, three-stage distance pipeline (difference,
// square, sum and compare), best-point tracking and the output register.
// ----------------------------------------------------------------------------
module npps_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  npps_pkg::t_in_word            i_in_data,
    input  npps_pkg::t_dp_cmd             i_cmd,
    input  logic [npps_pkg::CAP_W-1:0]    i_distance_cap,
    output npps_pkg::t_dp_stat            o_stat,
    output npps_pkg::t_out_word           o_out_data
);
    import npps_pkg::*;

    logic [CNT_W-1:0]   r_count;
    logic [CAP_SQ_W-1:0] w_cap_sq;
    t_coord             r_qx;
    t_coord             r_qy;

    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    t_coord             w_px;
    t_coord             w_py;
    logic [STORE_W-1:0] w_rdata;

    // stage 0: RAM read in flight
    logic               r_v0;
    logic [IDX_W-1:0]   r_i0;

    // stage 1: magnitudes of the differences
    t_coord               w_rx;
    t_coord               w_ry;
    logic signed [COORD_WIDTH:0] w_dx;
    logic signed [COORD_WIDTH:0] w_dy;
    logic [COORD_WIDTH:0] w_ax;
    logic [COORD_WIDTH:0] w_ay;
    logic [63:0]          w_ax64;
    logic [63:0]          w_ay64;
    logic                 r1_v;
    logic [IDX_W-1:0]     r1_i;
    t_coord               r1_x;
    t_coord               r1_y;
    logic [MAG_W-1:0]     r1_magx;
    logic [MAG_W-1:0]     r1_magy;
    logic                 r1_satx;
    logic                 r1_saty;

    // stage 2: squares
    logic [2*MAG_W-1:0]   w_sqx;
    logic [2*MAG_W-1:0]   w_sqy;
    logic                 r2_v;
    logic [IDX_W-1:0]     r2_i;
    t_coord               r2_x;
    t_coord               r2_y;
    logic [DIST_W-1:0]    r2_sqx;
    logic [DIST_W-1:0]    r2_sqy;

    // stage 3: sum and compare
    logic [DIST_W:0]      w_sum;
    logic [DIST_W-1:0]    w_d;
    logic [DIST_W-1:0]    r_best;
    logic [IDX_W-1:0]     r_bidx;
    t_coord               r_bx;
    t_coord               r_by;
    logic                 r_found;
    logic [DIST_W-1:0]    r_d0;
    t_coord               r_x0;
    t_coord               r_y0;

    t_out_word            r_out;
    t_out_word            w_res;
    logic [63:0]          w_idx64;

    assign w_px    = to_coord(i_in_data.point_x);
    assign w_py    = to_coord(i_in_data.point_y);
    assign w_we    = i_cmd.load && (i_in_data.restart_path || (r_count < CNT_W'(MAX_POINTS)));
    assign w_waddr = i_in_data.restart_path ? '0 : r_count[IDX_W-1:0];

    npps_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_POINTS)
    ) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({w_px, w_py}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_cap_sq = i_distance_cap * i_distance_cap;
        w_rx   = t_coord'(w_rdata[STORE_W-1:COORD_WIDTH]);
        w_ry   = t_coord'(w_rdata[COORD_WIDTH-1:0]);
        w_dx   = {r_qx[COORD_WIDTH-1], r_qx} - {w_rx[COORD_WIDTH-1], w_rx};
        w_dy   = {r_qy[COORD_WIDTH-1], r_qy} - {w_ry[COORD_WIDTH-1], w_ry};
        w_ax   = w_dx[COORD_WIDTH] ? (~w_dx + 1'b1) : w_dx;
        w_ay   = w_dy[COORD_WIDTH] ? (~w_dy + 1'b1) : w_dy;
        w_ax64 = 64'(w_ax);
        w_ay64 = 64'(w_ay);
        w_sqx  = r1_magx * r1_magx;
        w_sqy  = r1_magy * r1_magy;
        w_sum  = {1'b0, r2_sqx} + {1'b0, r2_sqy};
        w_d    = w_sum[DIST_W] ? DIST_MAX : w_sum[DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_v0    <= 1'b0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (i_in_data.restart_path) begin
                    r_count <= CNT_W'(1);
                end else if (r_count < CNT_W'(MAX_POINTS)) begin
                    r_count <= r_count + 1'b1;
                end
            end
            r_v0 <= i_cmd.rd_en;
            r1_v <= r_v0;
            r2_v <= r1_v;
            if (i_cmd.query_start) begin
                r_found <= 1'b0;
            end else if (r2_v && (w_d < r_best)) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_qx <= w_px;
            r_qy <= w_py;
        end
        r_i0 <= i_cmd.rd_addr;

        r1_i    <= r_i0;
        r1_x    <= w_rx;
        r1_y    <= w_ry;
        r1_magx <= w_ax64[MAG_W-1:0];
        r1_magy <= w_ay64[MAG_W-1:0];
        r1_satx <= |w_ax64[63:MAG_W];
        r1_saty <= |w_ay64[63:MAG_W];

        r2_i   <= r1_i;
        r2_x   <= r1_x;
        r2_y   <= r1_y;
        r2_sqx <= r1_satx ? DIST_MAX : DIST_W'(w_sqx);
        r2_sqy <= r1_saty ? DIST_MAX : DIST_W'(w_sqy);

        if (i_cmd.query_start) begin
            r_best <= DIST_W'(w_cap_sq);
            r_bidx <= '0;
        end else if (r2_v) begin
            // strictly below: the first of equal points wins
            if (w_d < r_best) begin
                r_best <= w_d;
                r_bidx <= r2_i;
                r_bx   <= r2_x;
                r_by   <= r2_y;
            end
            // keep point 0 for the nothing-under-the-cap answer
            if (r2_i == '0) begin
                r_d0 <= w_d;
                r_x0 <= r2_x;
                r_y0 <= r2_y;
            end
        end

        if (i_cmd.emit) begin
            r_out <= w_res;
        end
    end

    always_comb begin
        w_idx64 = 64'(r_bidx);
        if (r_count == '0) begin
            w_res            = '0;
            w_res.path_empty = 1'b1;
        end else begin
            w_res.nearest_index    = r_found ? w_idx64[INDEX_FIELD_W-1:0] : '0;
            w_res.nearest_x        = from_coord(r_found ? r_bx : r_x0);
            w_res.nearest_y        = from_coord(r_found ? r_by : r_y0);
            w_res.best_distance_sq = r_found ? r_best : r_d0;
            w_res.found            = r_found;
            w_res.path_empty       = 1'b0;
        end
    end

    assign o_stat.count     = r_count;
    assign o_stat.pipe_busy = r_v0 | r1_v | r2_v;
    assign o_out_data       = r_out;

endmodule

// ----- tb/sv/nearest_board_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_board_pkg: path model and result scoreboard for the path search
// Keeps its own copy of the stored path and the distance cap, works out the
// nearest point for every accepted query word and checks the output words.
// ----------------------------------------------------------------------------
package nearest_board_pkg;

    import npps_pkg::*;

    class nearest_point_board;

        t_coord              path_x [MAX_POINTS];
        t_coord              path_y [MAX_POINTS];
        int unsigned         path_len;
        logic [CAP_W-1:0]    cap;
        t_out_word           pending_nearest [$];
        int unsigned         mismatches;

        function new();
            path_len    = 0;
            cap         = CAP_RESET;
            mismatches  = 0;
        endfunction

        function void set_cap(input logic [CAP_W-1:0] value);
            cap = value;
        endfunction

        function longint unsigned gap_sq(input t_coord qx, input t_coord qy,
                                         input t_coord px, input t_coord py);
            longint          dx;
            longint          dy;
            longint unsigned s;
            dx = longint'(qx) - longint'(px);
            dy = longint'(qy) - longint'(py);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            s = dx * dx + dy * dy;
            if (s > DIST_MAX) s = DIST_MAX;
            return s;
        endfunction

        // Update the path on a load word, queue the nearest point on a query.
        function void note_word(input t_in_word w);
            t_coord          qx;
            t_coord          qy;
            t_out_word       r;
            longint unsigned lim;
            longint unsigned best;
            longint unsigned d;
            int unsigned     pick;
            int unsigned     i;
            bit              hit;
            qx = w.point_x;
            qy = w.point_y;
            if (w.cmd == CMD_LOAD) begin
                if (w.restart_path) path_len = 0;
                if (path_len < MAX_POINTS) begin
                    path_x[path_len] = qx;
                    path_y[path_len] = qy;
                    path_len++;
                end
                return;
            end
            r = '0;
            if (path_len == 0) begin
                r.path_empty = 1'b1;
                pending_nearest.push_back(r);
                return;
            end
            lim  = cap;
            best = lim * lim;
            pick = 0;
            hit  = 1'b0;
            for (i = 0; i < path_len; i++) begin
                d = gap_sq(qx, qy, path_x[i], path_y[i]);
                // strict compare keeps the first of equal points
                if (d < best) begin
                    best = d;
                    pick = i;
                    hit  = 1'b1;
                end
            end
            if (!hit) best = gap_sq(qx, qy, path_x[0], path_y[0]);
            r.nearest_index    = INDEX_FIELD_W'(pick);
            r.nearest_x        = path_x[pick];
            r.nearest_y        = path_y[pick];
            r.best_distance_sq = best[DIST_W-1:0];
            r.found            = hit;
            pending_nearest.push_back(r);
        endfunction

        task report_mismatch(input string what, input logic [63:0] got,
                             input logic [63:0] want);
            $display("[%0t] mismatch %s: got %0h, wanted %0h", $time, what, got, want);
            mismatches++;
        endtask

        task check_result(input t_out_word got);
            t_out_word want;
            if (pending_nearest.size() == 0) begin
                report_mismatch("output word with no query pending", got.nearest_index, 0);
                return;
            end
            want = pending_nearest.pop_front();
            if (got.nearest_index !== want.nearest_index)
                report_mismatch("nearest_index", got.nearest_index, want.nearest_index);
            if (got.nearest_x !== want.nearest_x)
                report_mismatch("nearest_x", got.nearest_x, want.nearest_x);
            if (got.nearest_y !== want.nearest_y)
                report_mismatch("nearest_y", got.nearest_y, want.nearest_y);
            if (got.best_distance_sq !== want.best_distance_sq)
                report_mismatch("best_distance_sq", got.best_distance_sq,
                                want.best_distance_sq);
            if (got.found !== want.found)
                report_mismatch("found", got.found, want.found);
            if (got.path_empty !== want.path_empty)
                report_mismatch("path_empty", got.path_empty, want.path_empty);
        endtask

    endclass

endpackage

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for nearest_path_point_search
// Loads paths and sends queries under random idling on both sides, steps the
// distance cap through its extremes over the APB port, and compares every
// output word with the scoreboard's nearest point.
// ----------------------------------------------------------------------------
module tb_top;

    import npps_pkg::*;
    import nearest_board_pkg::*;

    localparam int COORD_MIN = -(1 << 23);
    localparam int COORD_MAX = (1 << 23) - 1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_word              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_word             o_out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    nearest_point_board board = new();

    int               in_gap_max  = 19;
    int               out_gap_max = 19;
    int unsigned      words_sent  = 0;
    logic [CAP_W-1:0] cap_now     = CAP_RESET;

    nearest_path_point_search u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic t_in_word make_word(input logic cmd, input logic restart,
                                           input t_coord x, input t_coord y);
        t_in_word w;
        w.cmd          = cmd;
        w.restart_path = restart;
        w.point_x      = x;
        w.point_y      = y;
        return w;
    endfunction

    function automatic t_coord coord_near(input int mid, input int spread);
        int v;
        v = mid + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < COORD_MIN) v = COORD_MIN;
        if (v > COORD_MAX) v = COORD_MAX;
        return t_coord'(v);
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = w;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_word(w);
        words_sent++;
    endtask

    // Drop valid, then hold until every query has been answered.
    task automatic wait_idle(input int settle);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.pending_nearest.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_distance_cap(input logic [CAP_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_DISTANCE_CAP, 2'b00};
        pwdata  = APB_DATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_cap(value);
        cap_now = value;
        // read back through a second transfer
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[CAP_W-1:0] !== value)
            board.report_mismatch("distance_cap readback", prdata, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // A path around one spot, then queries near it.
    task automatic run_path_sequence();
        int     mid_x;
        int     mid_y;
        int     spread;
        int     n;
        int     q;
        int     k;
        logic   restart;
        t_coord px;
        t_coord py;
        mid_x = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        mid_y = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        case ($urandom_range(0, 3))
            0: spread = 256;
            1: spread = int'(cap_now) / 4 + 1;
            2: spread = int'(cap_now) + int'(cap_now) / 2 + 1;
            default: spread = 1 << 20;
        endcase
        restart = ($urandom_range(0, 3) != 0);
        n = $urandom_range(1, 24);
        px = coord_near(mid_x, spread);
        py = coord_near(mid_y, spread);
        for (k = 0; k < n; k++) begin
            // repeat the previous point now and then to make ties
            if (k == 0 || $urandom_range(0, 7) != 0) begin
                px = coord_near(mid_x, spread);
                py = coord_near(mid_y, spread);
            end
            send_word(make_word(CMD_LOAD, restart && k == 0, px, py));
        end
        q = $urandom_range(1, 4);
        for (k = 0; k < q; k++) begin
            if ($urandom_range(0, 3) == 0)
                send_word(make_word(CMD_QUERY, 1'($urandom_range(0, 1)), px, py));
            else
                send_word(make_word(CMD_QUERY, 1'($urandom_range(0, 1)),
                                    coord_near(mid_x, spread), coord_near(mid_y, spread)));
        end
    endtask

    task automatic run_noise();
        int n;
        int k;
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
            send_word(make_word(1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0),
                                t_coord'($urandom), t_coord'($urandom)));
    endtask

    // Receive side: stall a random while, then take one word.
    initial begin
        int gap;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            gap = $urandom_range(0, out_gap_max);
            if (gap != 0) begin
                i_out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            board.check_result(o_out_data);
        end
    end

    initial begin
        int          phase;
        int unsigned phase_start;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty path, corners, ties, no point under the cap.
        in_gap_max  = 3;
        out_gap_max = 3;
        send_word(make_word(CMD_QUERY, 1'b0, 0, 0));
        send_word(make_word(CMD_QUERY, 1'b1, COORD_MAX, COORD_MIN));
        send_word(make_word(CMD_LOAD, 1'b1, 0, 0));
        send_word(make_word(CMD_LOAD, 1'b0, COORD_MIN, COORD_MIN));
        send_word(make_word(CMD_LOAD, 1'b0, COORD_MAX, COORD_MAX));
        send_word(make_word(CMD_LOAD, 1'b0, COORD_MIN, COORD_MAX));
        send_word(make_word(CMD_LOAD, 1'b0, 100, -100));
        send_word(make_word(CMD_LOAD, 1'b0, 100, -100));
        send_word(make_word(CMD_QUERY, 1'b0, 0, 0));
        send_word(make_word(CMD_QUERY, 1'b0, 90, -90));
        send_word(make_word(CMD_QUERY, 1'b0, COORD_MAX, COORD_MAX));
        send_word(make_word(CMD_QUERY, 1'b0, COORD_MAX, COORD_MIN));
        send_word(make_word(CMD_QUERY, 1'b1, COORD_MIN, COORD_MAX));
        wait_idle(8);
        write_distance_cap('1);
        send_word(make_word(CMD_QUERY, 1'b0, COORD_MAX, COORD_MIN));
        send_word(make_word(CMD_QUERY, 1'b0, 1000, 1000));
        wait_idle(8);
        write_distance_cap('0);
        send_word(make_word(CMD_QUERY, 1'b0, 0, 0));
        send_word(make_word(CMD_QUERY, 1'b0, 100, -100));
        wait_idle(8);
        write_distance_cap(CAP_RESET);
        send_word(make_word(CMD_LOAD, 1'b1, 5, 5));
        send_word(make_word(CMD_QUERY, 1'b0, -5, -5));

        // Random phases, one cap setting each.
        for (phase = 0; phase < 8; phase++) begin
            wait_idle(8);
            case (phase)
                0: write_distance_cap('1);
                1: write_distance_cap('0);
                2: write_distance_cap(CAP_W'($urandom));
                3: write_distance_cap(CAP_RESET);
                4: write_distance_cap(CAP_W'(1));
                5: write_distance_cap(CAP_W'($urandom_range(256, 65535)));
                6: write_distance_cap(CAP_W'($urandom));
                default: write_distance_cap(CAP_W'(1000));
            endcase
            in_gap_max  = (phase % 3 == 1) ? 0 : 19;
            out_gap_max = (phase % 4 == 2) ? 0 : 19;
            phase_start = words_sent;
            while (words_sent - phase_start < 64) begin
                if ($urandom_range(0, 9) < 7)
                    run_path_sequence();
                else
                    run_noise();
                if ($urandom_range(0, 11) == 0)
                    wait_idle(0);
            end
        end

        wait_idle(20);
        if (board.mismatches == 0 && board.pending_nearest.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
